// File: sv/sfd_pkg.sv
// Package: shared types, constants and the CRC16 byte update for the short frame deframer.
package sfd_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] crc_t;

	// Frame delimiters
	localparam byte_t START_BYTE = 8'h02;
	localparam byte_t END_BYTE   = 8'h03;

	// CRC16-XMODEM: polynomial 0x1021, seed zero, no final xor
	localparam crc_t CRC_POLY = 16'h1021;
	localparam crc_t CRC_TOP  = 16'h8000;
	localparam crc_t CRC_SEED = 16'h0000;

	// Reset value of the payload length limit
	localparam byte_t MAX_PAYLOAD_RESET = 8'd192;

	// Receive phases
	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_DATA = 3'd2,
		PH_CRCH = 3'd3,
		PH_CRCL = 3'd4,
		PH_END  = 3'd5
	} phase_t;

	// One result: a payload byte or the end-of-frame verdict
	typedef struct packed {
		byte_t out_byte;
		byte_t byte_index;
		logic  is_verdict;
		logic  frame_ok;
		byte_t frame_length;
	} result_t;

	// Advance the CRC over one byte, MSB first
	function automatic crc_t crc16_byte(input crc_t crc, input byte_t b);
		crc_t c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: sv/sfd_in_if.sv
// Interface: received byte channel with valid/ready handshake.
interface sfd_in_if;
	logic           valid;
	logic           ready;
	sfd_pkg::byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// File: sv/sfd_out_if.sv
// Interface: result channel carrying payload bytes and frame verdicts.
interface sfd_out_if;
	logic           valid;
	logic           ready;
	sfd_pkg::byte_t out_byte;
	sfd_pkg::byte_t byte_index;
	logic           is_verdict;
	logic           frame_ok;
	sfd_pkg::byte_t frame_length;

	modport source (output valid, output out_byte, output byte_index, output is_verdict,
		output frame_ok, output frame_length, input ready);
	modport sink   (input valid, input out_byte, input byte_index, input is_verdict,
		input frame_ok, input frame_length, output ready);
endinterface

// File: sv/short_frame_deframer_crc16.sv
// Top level: short frame deframer with streaming CRC16-XMODEM check.
//
//   port       dir   handshake       payload
//   rx         sink  valid/ready     in_byte
//   res        src   valid/ready     out_byte, byte_index, is_verdict, frame_ok, frame_length
//   cfg_we     in    write strobe    cfg_wdata = max_payload
//
// One byte is accepted every cycle while the skid stage is empty; its phase, length check and 8-bit CRC step
// settle in the same cycle and any result lands in the output register, or in the skid stage while the output is held.
// Throughput is set by the two-entry result buffer: rx.ready drops only while
// the skid stage holds a result, i.e. after res.ready has been low.
// After reset the block hunts for a start byte and max_payload is 192.
module short_frame_deframer_crc16 (
	input  logic           clk,
	input  logic           arst_n,
	sfd_in_if.sink         rx,
	sfd_out_if.source      res,
	input  logic           cfg_we,
	input  sfd_pkg::byte_t cfg_wdata
);

	sfd_pkg::byte_t   max_payload_q;
	logic             acc;
	logic             buf_ready;
	logic             res_valid;
	sfd_pkg::result_t res_data;

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= sfd_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	assign rx.ready = buf_ready;
	assign acc      = rx.valid && buf_ready;

	sfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.rx_byte     (rx.in_byte),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res_data)
	);

	sfd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_data),
		.ready     (buf_ready),
		.res       (res)
	);

endmodule

// File: sv/sfd_parser.sv
// Frame parser: phase machine, length check and running CRC, one byte per request.
module sfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  sfd_pkg::byte_t    rx_byte,
	input  sfd_pkg::byte_t    max_payload,
	output logic              res_valid,
	output sfd_pkg::result_t  res
);

	sfd_pkg::phase_t phase_q, phase_d;
	sfd_pkg::byte_t  len_q, len_d;
	sfd_pkg::byte_t  seen_q, seen_d;
	sfd_pkg::crc_t   crc_q, crc_d;
	sfd_pkg::crc_t   rcrc_q, rcrc_d;
	sfd_pkg::byte_t  seen_inc;

	assign seen_inc = seen_q + 8'd1;

	// Hold phase and frame context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_HUNT;
			len_q   <= '0;
			seen_q  <= '0;
			crc_q   <= sfd_pkg::CRC_SEED;
			rcrc_q  <= '0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			crc_q   <= crc_d;
			rcrc_q  <= rcrc_d;
		end
	end

	// Advance the phase on each accepted byte and form its result
	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		seen_d    = seen_q;
		crc_d     = crc_q;
		rcrc_d    = rcrc_q;
		res_valid = 1'b0;
		res       = '0;
		if (acc) begin
			case (phase_q)
				sfd_pkg::PH_HUNT: begin
					if (rx_byte == sfd_pkg::START_BYTE) begin
						phase_d = sfd_pkg::PH_LEN;
					end
				end
				sfd_pkg::PH_LEN: begin
					// drop a zero or oversized length
					if (rx_byte == 8'd0 || rx_byte > max_payload) begin
						phase_d = sfd_pkg::PH_HUNT;
					end else begin
						len_d   = rx_byte;
						seen_d  = '0;
						crc_d   = sfd_pkg::CRC_SEED;
						phase_d = sfd_pkg::PH_DATA;
					end
				end
				sfd_pkg::PH_DATA: begin
					res_valid        = 1'b1;
					res.out_byte     = rx_byte;
					res.byte_index   = seen_q;
					res.frame_length = len_q;
					crc_d            = sfd_pkg::crc16_byte(crc_q, rx_byte);
					seen_d           = seen_inc;
					if (seen_inc >= len_q) begin
						phase_d = sfd_pkg::PH_CRCH;
					end
				end
				sfd_pkg::PH_CRCH: begin
					rcrc_d  = {rx_byte, 8'h00};
					phase_d = sfd_pkg::PH_CRCL;
				end
				sfd_pkg::PH_CRCL: begin
					rcrc_d  = {rcrc_q[15:8], rx_byte};
					phase_d = sfd_pkg::PH_END;
				end
				sfd_pkg::PH_END: begin
					res_valid        = 1'b1;
					res.is_verdict   = 1'b1;
					res.frame_ok     = (rx_byte == sfd_pkg::END_BYTE) && (rcrc_q == crc_q);
					res.frame_length = len_q;
					phase_d          = sfd_pkg::PH_HUNT;
				end
				default: begin
					phase_d = sfd_pkg::PH_HUNT;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// Payload count stays below the announced length while in the payload phase
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sfd_pkg::PH_DATA |-> seen_q < len_q)
		else $error("payload count reached announced length inside payload phase");

	// The announced length is never zero once a frame is open
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sfd_pkg::PH_DATA || phase_q == sfd_pkg::PH_CRCH ||
		 phase_q == sfd_pkg::PH_CRCL || phase_q == sfd_pkg::PH_END) |-> len_q != 8'd0)
		else $error("open frame with zero length");
`endif

endmodule

// File: sv/sfd_obuf.sv
// Result buffer: output register plus skid stage between the parser and the consumer.
module sfd_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfd_pkg::result_t push_data,
	output logic             ready,
	sfd_out_if.source        res
);

	logic             out_valid_q;
	logic             skid_valid_q;
	sfd_pkg::result_t out_q;
	sfd_pkg::result_t skid_q;
	logic             pop;

	assign pop   = out_valid_q && res.ready;
	assign ready = !skid_valid_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload: refill the output from the skid stage, else load or park the new result
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.out_byte     = out_q.out_byte;
	assign res.byte_index   = out_q.byte_index;
	assign res.is_verdict   = out_q.is_verdict;
	assign res.frame_ok     = out_q.frame_ok;
	assign res.frame_length = out_q.frame_length;

`ifndef SYNTHESIS
	// The skid stage only fills behind a full output register
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while output is empty");

	// No new result arrives while the skid stage is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed into a full buffer");
`endif

endmodule

// File: verif/sfd_scoreboard_pkg.sv
// Scoreboard class: predicts deframer outputs from accepted bytes and checks the result stream.
`timescale 1ns / 100ps
package sfd_scoreboard_pkg;

	class frame_scoreboard_t;
		// Shadow of the deframer state and its length limit
		sfd_pkg::byte_t   limit;
		sfd_pkg::phase_t  phase;
		sfd_pkg::byte_t   frame_len;
		sfd_pkg::byte_t   seen;
		sfd_pkg::crc_t    calc_crc;
		sfd_pkg::crc_t    rx_crc;

		// Payload bytes and verdicts not yet seen on the result channel
		sfd_pkg::result_t due_outputs[$];

		int mismatches;
		int payload_results;
		int good_verdicts;
		int bad_verdicts;
		int rejected_lengths;

		function new();
			limit            = sfd_pkg::MAX_PAYLOAD_RESET;
			phase            = sfd_pkg::PH_HUNT;
			frame_len        = '0;
			seen             = '0;
			calc_crc         = sfd_pkg::CRC_SEED;
			rx_crc           = '0;
			mismatches       = 0;
			payload_results  = 0;
			good_verdicts    = 0;
			bad_verdicts     = 0;
			rejected_lengths = 0;
		endfunction

		// Shift one byte through the CRC, one feedback bit at a time
		function sfd_pkg::crc_t crc_step(sfd_pkg::crc_t c, sfd_pkg::byte_t b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c  = {c[14:0], 1'b0};
				if (fb) begin
					c = c ^ sfd_pkg::CRC_POLY;
				end
			end
			return c;
		endfunction

		function void set_limit(sfd_pkg::byte_t v);
			limit = v;
		endfunction

		function int pending();
			return due_outputs.size();
		endfunction

		// Advance the shadow state over one accepted byte; queue any output it causes
		function void note_rx_byte(sfd_pkg::byte_t b);
			sfd_pkg::result_t r;
			r = '0;
			case (phase)
				sfd_pkg::PH_HUNT: begin
					if (b == sfd_pkg::START_BYTE) begin
						phase = sfd_pkg::PH_LEN;
					end
				end
				sfd_pkg::PH_LEN: begin
					if (b == 8'd0 || b > limit) begin
						phase = sfd_pkg::PH_HUNT;
						rejected_lengths++;
					end else begin
						frame_len = b;
						seen      = '0;
						calc_crc  = sfd_pkg::CRC_SEED;
						phase     = sfd_pkg::PH_DATA;
					end
				end
				sfd_pkg::PH_DATA: begin
					r.out_byte     = b;
					r.byte_index   = seen;
					r.frame_length = frame_len;
					due_outputs.push_back(r);
					calc_crc = crc_step(calc_crc, b);
					seen     = seen + 8'd1;
					if (seen >= frame_len) begin
						phase = sfd_pkg::PH_CRCH;
					end
				end
				sfd_pkg::PH_CRCH: begin
					rx_crc = {b, 8'h00};
					phase  = sfd_pkg::PH_CRCL;
				end
				sfd_pkg::PH_CRCL: begin
					rx_crc[7:0] = b;
					phase       = sfd_pkg::PH_END;
				end
				sfd_pkg::PH_END: begin
					r.is_verdict   = 1'b1;
					r.frame_ok     = (b == sfd_pkg::END_BYTE) && (rx_crc == calc_crc);
					r.frame_length = frame_len;
					due_outputs.push_back(r);
					phase = sfd_pkg::PH_HUNT;
				end
				default: begin
					phase = sfd_pkg::PH_HUNT;
				end
			endcase
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Match one accepted result against the oldest expectation
		function void check_result(sfd_pkg::result_t got);
			sfd_pkg::result_t want;
			if (due_outputs.size() == 0) begin
				$error("result with nothing expected: out_byte %0d byte_index %0d verdict %0b",
					got.out_byte, got.byte_index, got.is_verdict);
				mismatches++;
				return;
			end
			want = due_outputs.pop_front();
			compare_field("out_byte", want.out_byte, got.out_byte);
			compare_field("byte_index", want.byte_index, got.byte_index);
			compare_field("is_verdict", {7'd0, want.is_verdict}, {7'd0, got.is_verdict});
			compare_field("frame_ok", {7'd0, want.frame_ok}, {7'd0, got.frame_ok});
			compare_field("frame_length", want.frame_length, got.frame_length);
			if (!want.is_verdict) begin
				payload_results++;
			end else if (want.frame_ok) begin
				good_verdicts++;
			end else begin
				bad_verdicts++;
			end
		endfunction

		function int failures();
			return mismatches + due_outputs.size();
		endfunction
	endclass

endpackage

// File: verif/short_frame_deframer_crc16_test.sv
// Testbench top: drives byte streams and limit settings into the deframer and scores its results.
`timescale 1ns / 100ps
module short_frame_deframer_crc16_test;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 6;

	typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_END, FLAW_CUT} flaw_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_we;
	sfd_pkg::byte_t cfg_wdata;

	sfd_in_if  rx_if();
	sfd_out_if res_if();

	sfd_scoreboard_pkg::frame_scoreboard_t sb = new();

	int               src_idle_pct;
	int               snk_idle_pct;
	int               sent_bytes;
	int               limit_settings;
	int               cycle_count;
	sfd_pkg::result_t seen_result;

	short_frame_deframer_crc16 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("short_frame_deframer_crc16_test failed");
			$finish;
		end
	end

	// Check accepted results, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid === 1'b1 && res_if.ready) begin
				seen_result.out_byte     = res_if.out_byte;
				seen_result.byte_index   = res_if.byte_index;
				seen_result.is_verdict   = res_if.is_verdict;
				seen_result.frame_ok     = res_if.frame_ok;
				seen_result.frame_length = res_if.frame_length;
				sb.check_result(seen_result);
			end
			res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Offer one byte, with random gaps, and hold it until the request is taken
	task automatic send_byte(input sfd_pkg::byte_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.in_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) begin
			@(posedge clk);
		end
		sb.note_rx_byte(b);
		sent_bytes++;
	endtask

	// Send a frame around the given payload, optionally damaged
	task automatic send_frame(input sfd_pkg::byte_t body[$], input flaw_t flaw);
		sfd_pkg::crc_t  crc;
		sfd_pkg::byte_t tail;
		int             stop_at;
		crc     = sfd_pkg::CRC_SEED;
		stop_at = (flaw == FLAW_CUT) ? $urandom_range(body.size() - 1, 0) : body.size();
		send_byte(sfd_pkg::START_BYTE);
		send_byte(sfd_pkg::byte_t'(body.size()));
		for (int i = 0; i < stop_at; i++) begin
			send_byte(body[i]);
			crc = sb.crc_step(crc, body[i]);
		end
		if (flaw == FLAW_CUT) begin
			return;
		end
		if (flaw == FLAW_CRC) begin
			crc = crc ^ (16'h0001 << $urandom_range(15));
		end
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
		tail = sfd_pkg::END_BYTE;
		if (flaw == FLAW_END) begin
			do tail = sfd_pkg::byte_t'($urandom); while (tail == sfd_pkg::END_BYTE);
		end
		send_byte(tail);
	endtask

	// Drop valid and wait until every expected result has drained
	task automatic settle();
		rx_if.valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input sfd_pkg::byte_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_limit(v);
		limit_settings++;
	endtask

	// Mostly short frames, now and then up to the limit
	function automatic int pick_length();
		int hi;
		hi = (sb.limit == 8'd0) ? 20 : sb.limit;
		if ($urandom_range(19) == 0) begin
			return $urandom_range(hi, 1);
		end
		return $urandom_range((hi < 12) ? hi : 12, 1);
	endfunction

	// Random mix: mostly clean frames, some damaged, cut, rejected or noise
	task automatic run_random(input int n_items);
		sfd_pkg::byte_t body[$];
		int             start;
		int             pick;
		int             len;
		start = sent_bytes;
		while (sent_bytes - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 89) begin
				len  = pick_length();
				body = {};
				repeat (len) body.push_back(sfd_pkg::byte_t'($urandom));
				if (pick < 70) begin
					send_frame(body, FLAW_NONE);
				end else if (pick < 78) begin
					send_frame(body, FLAW_CRC);
				end else if (pick < 84) begin
					send_frame(body, FLAW_END);
				end else begin
					send_frame(body, FLAW_CUT);
				end
			end else if (pick < 94) begin
				send_byte(sfd_pkg::START_BYTE);
				if (sb.limit == 8'd255 || $urandom_range(1) == 0) begin
					send_byte(8'd0);
				end else begin
					send_byte(sfd_pkg::byte_t'($urandom_range(255, sb.limit + 1)));
				end
			end else begin
				repeat ($urandom_range(4, 1)) send_byte(sfd_pkg::byte_t'($urandom));
			end
		end
	endtask

	initial begin
		sfd_pkg::byte_t body[$];
		sfd_pkg::crc_t  crc;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		rx_if.valid    = 1'b0;
		rx_if.in_byte  = '0;
		res_if.ready   = 1'b0;
		cycle_count    = 0;
		sent_bytes     = 0;
		limit_settings = 1;
		src_idle_pct   = 11;
		snk_idle_pct   = 77;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: noise while hunting, zero and oversize lengths
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(sfd_pkg::START_BYTE);
		send_byte(8'd0);
		send_byte(sfd_pkg::START_BYTE);
		send_byte(sfd_pkg::MAX_PAYLOAD_RESET + 8'd1);
		// Good one-byte frame, delimiters inside the payload, bad end byte
		body = {8'hFF};
		send_frame(body, FLAW_NONE);
		body = {sfd_pkg::START_BYTE, sfd_pkg::END_BYTE};
		send_frame(body, FLAW_CRC);
		body = {8'h00};
		send_frame(body, FLAW_END);

		// Largest limit, and a frame of the largest length
		settle();
		write_limit(8'd255);
		body = {};
		repeat (255) body.push_back(sfd_pkg::byte_t'($urandom));
		send_frame(body, FLAW_NONE);
		run_random(40);

		// Start a three-byte frame, then lower the limit to one mid-frame
		body = {};
		repeat (3) body.push_back(sfd_pkg::byte_t'($urandom));
		crc = sfd_pkg::CRC_SEED;
		foreach (body[i]) crc = sb.crc_step(crc, body[i]);
		send_byte(sfd_pkg::START_BYTE);
		send_byte(8'd3);
		send_byte(body[0]);
		send_byte(body[1]);
		settle();
		write_limit(8'd1);
		send_byte(body[2]);
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
		send_byte(sfd_pkg::END_BYTE);
		send_byte(sfd_pkg::START_BYTE);
		send_byte(8'd2);
		run_random(200);

		// Swap the idling sides; a zero limit rejects every frame
		src_idle_pct = 77;
		snk_idle_pct = 11;
		settle();
		write_limit(8'd0);
		run_random(120);
		settle();
		write_limit(sfd_pkg::byte_t'($urandom_range(254, 2)));
		run_random(300);

		// No idling on either side
		src_idle_pct = 0;
		snk_idle_pct = 0;
		settle();
		write_limit(sfd_pkg::MAX_PAYLOAD_RESET);
		run_random(300);
		settle();
		write_limit(8'd255);
		run_random(300);

		settle();
		$display("covered %0d bytes: %0d payload results, %0d good and %0d bad verdicts",
			sent_bytes, sb.payload_results, sb.good_verdicts, sb.bad_verdicts);
		$display("%0d length bytes rejected across %0d limit settings, 0, 1 and 255 among them",
			sb.rejected_lengths, limit_settings);
		if (sb.failures() == 0) begin
			$display("short_frame_deframer_crc16_test passed");
		end else begin
			$display("short_frame_deframer_crc16_test failed");
		end
		$finish;
	end

endmodule
